### rtl/grt_pkg.sv
// grt_pkg: shared types, constants and register codes for the grain interval trigger
// used by every module under rtl; depends on nothing else
package grt_pkg;

  // default table size and queue depth
  localparam int unsigned MAX_GRAINS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // reset value of the fixed tone duration
  localparam logic [14:0] FIXED_DUR_RST = 15'd20;

  // duration numerator in ms and number of quotient bits the divider produces
  localparam logic [17:0] DUR_NUM   = 18'd1000;
  localparam int unsigned DIV_STEPS = 10;

  // volume scaling: floor(x / 100) as (x * VOL_RECIP) >> VOL_SHIFT for x below 2^14
  localparam logic [12:0] VOL_RECIP = 13'd5243;
  localparam int unsigned VOL_SHIFT = 19;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GRAIN_COUNT = 2'd0,
    CFG_FORCE_DUR   = 2'd1,
    CFG_FIXED_DUR   = 2'd2
  } cfg_idx_e;

  // input opcodes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TABLE  = 1'b1
  } op_e;

  // one input beat, split into its fields
  typedef struct packed {
    op_e         opcode;
    logic [7:0]  pressure;
    logic [7:0]  entry_index;
    logic [7:0]  entry_threshold;
    logic [14:0] entry_frequency;
    logic [6:0]  entry_amplitude;
  } in_item_t;

  // tone job handed from the tracker to the tone unit
  typedef struct packed {
    logic [7:0]  grain;
    logic [14:0] freq;
    logic [6:0]  amp;
  } tone_job_t;

  // finished tone
  typedef struct packed {
    logic [7:0]  grain_index;
    logic [14:0] tone_frequency;
    logic [6:0]  tone_volume;
    logic [14:0] tone_duration_ms;
  } tone_t;

  // tone settings seen by the tone unit
  typedef struct packed {
    logic        force_duration;
    logic [14:0] fixed_duration_ms;
  } tone_cfg_t;

endpackage

### rtl/grain_interval_trigger.sv
// grain_interval_trigger: top level with configuration registers and stream packing
// depends on grt_pkg, grt_front, grt_fifo and grt_back
//
// Pressure samples and grain table writes enter on the slave stream; tuser is the opcode
// (0 sample, 1 table write). A table write, or a sample while no grains are in use, is
// handled in the idle state. Otherwise a sample moves to a compare state that decides on
// the registered threshold read, and a sample that plays a grain then passes a read state,
// for the registered frequency and amplitude read of the grain tables, and a push state.
// Each tone then passes the tone unit's idle, divide and done states, the divide state
// being the one-bit-a-step duration divider, and the tone unit takes no new job until the
// last one is done; a two-entry job queue lets the tracker run ahead of the tone unit, and
// the output register holds a finished tone while the next one is computed. Table entries
// read before they are written return unspecified values. Configuration writes are taken
// at once and must be made while the block is idle; writing the grain count restarts tracking at grain zero.
module grain_interval_trigger import grt_pkg::*; #(
  parameter int unsigned MAX_GRAINS = MAX_GRAINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pressure[7:0], entry_index[15:8], entry_threshold[23:16],
  // entry_frequency[38:24], entry_amplitude[45:39], zero fill
  input  logic [47:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // grain_index[7:0], tone_frequency[22:8], tone_volume[29:23],
  // tone_duration_ms[44:30], zero fill
  output logic [47:0] m_axis_tdata,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  logic [7:0]  grain_count_q;
  logic        force_dur_q;
  logic [14:0] fixed_dur_q;

  logic      cfg_we, count_clr;
  in_item_t  in_item;
  tone_cfg_t tone_cfg;
  logic      push_valid, push_ready, job_valid, job_ready;
  tone_job_t push_job, job;
  tone_t     tone;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign count_clr   = cfg_we && (cfg_index_i == CFG_GRAIN_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grain_count_q <= 8'd0;
      force_dur_q   <= 1'b0;
      fixed_dur_q   <= FIXED_DUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_GRAIN_COUNT: grain_count_q <= cfg_data_i[7:0];
        CFG_FORCE_DUR:   force_dur_q   <= cfg_data_i[0];
        CFG_FIXED_DUR:   fixed_dur_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // unpack the input beat
  assign in_item.opcode          = op_e'(s_axis_tuser);
  assign in_item.pressure        = s_axis_tdata[7:0];
  assign in_item.entry_index     = s_axis_tdata[15:8];
  assign in_item.entry_threshold = s_axis_tdata[23:16];
  assign in_item.entry_frequency = s_axis_tdata[38:24];
  assign in_item.entry_amplitude = s_axis_tdata[45:39];

  assign tone_cfg.force_duration    = force_dur_q;
  assign tone_cfg.fixed_duration_ms = fixed_dur_q;

  grt_front #(
    .MAX_GRAINS (MAX_GRAINS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_item_i     (in_item),
    .grain_count_i (grain_count_q),
    .count_clr_i   (count_clr),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_job_o    (push_job)
  );

  grt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job)
  );

  grt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .cfg_i       (tone_cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .tone_o      (tone)
  );

  // pack the output beat
  assign m_axis_tdata = {3'b000, tone.tone_duration_ms, tone.tone_volume,
                         tone.tone_frequency, tone.grain_index};

endmodule

### rtl/grt_fifo.sv
// grt_fifo: short queue of tone jobs between the tracker and the tone unit
// depends on grt_pkg for the job type
module grt_fifo import grt_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  tone_job_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output tone_job_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tone_job_t       slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/grt_front.sv
// grt_front: accepts input beats, loads the grain tables and tracks the pressure interval
// depends on grt_pkg; pushes tone jobs into grt_fifo
module grt_front import grt_pkg::*; #(
  parameter int unsigned MAX_GRAINS = MAX_GRAINS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  input  logic [7:0] grain_count_i,
  input  logic       count_clr_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output tone_job_t  push_job_o
);

  localparam int unsigned IdxW = $clog2(MAX_GRAINS);
  localparam logic [8:0]  MaxG = 9'(MAX_GRAINS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CMP,
    F_RD,
    F_PUSH
  } front_state_e;

  front_state_e    state_q;
  logic [IdxW-1:0] lower_q, upper_q, played_q;
  logic [7:0]      pressure_q;
  logic [7:0]      thr_lo_q, thr_hi_q;
  logic [14:0]     frq_rd_q;
  logic [6:0]      amp_rd_q;

  logic [7:0]  thr_mem [MAX_GRAINS];
  logic [14:0] frq_mem [MAX_GRAINS];
  logic [6:0]  amp_mem [MAX_GRAINS];

  logic [8:0] usable;
  logic       accept, track_ok, wr_en;
  logic       go_down, go_up, play;

  // usable grain count and whether the indices lie inside it
  assign usable   = ({1'b0, grain_count_i} < MaxG) ? {1'b0, grain_count_i} : MaxG;
  assign track_ok = (usable != 9'd0) && (9'(lower_q) < usable) && (9'(upper_q) < usable);

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (in_item_i.opcode == OP_TABLE)
                      && ({1'b0, in_item_i.entry_index} < MaxG);

  // boundary decisions on the registered thresholds
  assign go_down = (pressure_q < thr_lo_q);
  assign go_up   = !go_down && (thr_hi_q <= pressure_q);
  assign play    = (go_down && (played_q != lower_q)) || (go_up && (played_q != upper_q));

  // job of the newly played grain
  assign push_valid_o     = (state_q == F_PUSH);
  assign push_job_o.grain = 8'(played_q);
  assign push_job_o.freq  = frq_rd_q;
  assign push_job_o.amp   = amp_rd_q;

  // grain tables: one write port, registered reads at the tracking indices
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      thr_mem[in_item_i.entry_index[IdxW-1:0]] <= in_item_i.entry_threshold;
      frq_mem[in_item_i.entry_index[IdxW-1:0]] <= in_item_i.entry_frequency;
      amp_mem[in_item_i.entry_index[IdxW-1:0]] <= in_item_i.entry_amplitude;
    end
    thr_lo_q <= thr_mem[lower_q];
    thr_hi_q <= thr_mem[upper_q];
    frq_rd_q <= frq_mem[played_q];
    amp_rd_q <= amp_mem[played_q];
    if (accept) begin
      pressure_q <= in_item_i.pressure;
    end
  end

  // tracker state machine and interval indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      lower_q  <= '0;
      upper_q  <= '0;
      played_q <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept && (in_item_i.opcode == OP_SAMPLE) && track_ok) begin
            state_q <= F_CMP;
          end
        end
        F_CMP: begin
          if (!count_clr_i) begin
            if (go_down) begin
              played_q <= lower_q;
              if (lower_q != '0) begin
                upper_q <= lower_q;
                lower_q <= lower_q - 1'b1;
              end
            end else if (go_up) begin
              played_q <= upper_q;
              if ((9'(upper_q) + 9'd1) < usable) begin
                lower_q <= upper_q;
                upper_q <= upper_q + 1'b1;
              end
            end
          end
          state_q <= play ? F_RD : F_IDLE;
        end
        F_RD: begin
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
      // a new grain count restarts tracking from the bottom
      if (count_clr_i) begin
        lower_q  <= '0;
        upper_q  <= '0;
        played_q <= '0;
      end
    end
  end

  // interval is always two neighbours, or one grain at an end
  a_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upper_q == lower_q) || (upper_q == lower_q + 1'b1))
    else $error("tracking indices not adjacent");

  // the played grain is always one of the interval boundaries
  a_played_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (played_q == lower_q) || (played_q == upper_q))
    else $error("played grain outside interval");

  // upper index never passes the usable count
  a_upper_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (usable != 9'd0) |-> (9'(upper_q) < usable))
    else $error("upper index beyond usable count");

  // a comparison that plays moves on to the table read
  a_play_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CMP && play) |=> (state_q == F_RD))
    else $error("tone read skipped after play");

endmodule

### rtl/grt_back.sv
// grt_back: turns tone jobs into finished tones: volume scaling and iterative duration divide
// depends on grt_pkg; pops jobs from grt_fifo and drives the output register
module grt_back import grt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  tone_job_t job_i,
  input  tone_cfg_t cfg_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tone_t     tone_o
);

  localparam logic [3:0] LastStep = 4'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

  back_state_e          state_q;
  logic [3:0]           step_q;
  logic                 out_valid_q;
  logic [7:0]           grain_q;
  logic [14:0]          freq_q;
  logic [13:0]          prod_q;
  logic [17:0]          rem_q;
  logic [DIV_STEPS-1:0] quo_q;
  tone_t                tone_q;

  logic        pop, out_free, take;
  logic [17:0] num_sel, rem_d;
  logic [27:0] div_sh;
  logic [26:0] vol_mul;
  logic [7:0]  vol_raw;
  logic [6:0]  vol;
  logic [14:0] dur_calc, dur;

  assign job_ready_o = (state_q == B_IDLE);
  assign pop         = job_valid_i && job_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign tone_o      = tone_q;

  // numerator: 1000 doubled until it reaches four times the frequency
  always_comb begin
    num_sel = DUR_NUM;
    for (int j = 8; j >= 0; j--) begin
      if ((DUR_NUM << j) >= 18'({job_i.freq, 2'b00})) begin
        num_sel = DUR_NUM << j;
      end
    end
  end

  // one restoring divide step; a zero frequency gives all ones and saturates
  assign div_sh = 28'(freq_q) << step_q;
  assign take   = (28'(rem_q) >= div_sh);
  assign rem_d  = take ? (rem_q - div_sh[17:0]) : rem_q;

  // volume and duration of the finished tone
  assign vol_mul  = 27'(prod_q) * 27'(VOL_RECIP);
  assign vol_raw  = vol_mul[VOL_SHIFT+7:VOL_SHIFT];
  assign vol      = (vol_raw > 8'd127) ? 7'd127 : vol_raw[6:0];
  assign dur_calc = (quo_q > DIV_STEPS'(255)) ? 15'd255 : 15'(quo_q);
  assign dur      = cfg_i.force_duration ? cfg_i.fixed_duration_ms : dur_calc;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      grain_q <= job_i.grain;
      freq_q  <= job_i.freq;
      prod_q  <= {job_i.amp, 7'd0} - 14'(job_i.amp);
      rem_q   <= num_sel;
      quo_q   <= '0;
    end
    if (state_q == B_DIV) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_STEPS-2:0], take};
    end
    if (state_q == B_DONE && out_free) begin
      tone_q.grain_index      <= grain_q;
      tone_q.tone_frequency   <= freq_q;
      tone_q.tone_volume      <= vol;
      tone_q.tone_duration_ms <= dur;
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop) begin
            step_q  <= LastStep;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          if (step_q == 4'd0) begin
            state_q <= B_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        B_DONE: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule
